// File: design/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter.
// No dependencies; compiled first.
package mf3_pkg;

    // Operation codes carried with each input transfer.
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 13;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

    // Row counter runs one past the frame height during flush.
    localparam int ROW_BITS = 14;

    localparam int WIN_N    = 9;
    localparam int MID_RANK = 4;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]  width;
        logic [HEIGHT_BITS-1:0] height;
        logic                   restart;
    } t_cfg;

    typedef struct packed {
        logic ready;
        logic pend_nz;
        logic pre_step;
    } t_front_sts;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tap_sts;

endpackage

// File: design/mf3_pix_if.sv
// Input stream channel of the median filter: operation and pixel.
// No dependencies.
interface mf3_pix_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, operation, pixel_value, input ready);
    modport sink   (input valid, operation, pixel_value, output ready);
endinterface

// File: design/mf3_res_if.sv
// Result stream channel of the median filter: median and end-of-frame flag.
// No dependencies.
interface mf3_res_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] median_value;
    logic                  last_of_frame;

    modport source (output valid, median_value, last_of_frame, input ready);
    modport sink   (input valid, median_value, last_of_frame, output ready);
endinterface

// File: design/median_filter_3x3_top.sv
// 3x3 median filter, top level. Uses mf3_pkg, mf3_pix_if, mf3_res_if,
// mf3_front and mf3_median.
// A result passes the tap register in mf3_front and then the output register.
// Throughput: one input transfer per cycle unless the result path stalls;
// the first flush of a one-row frame waits for a window step with no result.
// Reset: counters and flush count cleared, width 640, height 480; line stores
// are not cleared, and there is no clearing pass.
module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    mf3_pix_if.sink                  i_pix,
    mf3_res_if.source                o_res
);
    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic                   r_out_valid;
    logic [PIXEL_BITS-1:0]  r_med;
    logic                   r_last;

    t_cfg                             cfg;
    t_front_sts                       front_sts;
    t_tap_sts                         tap_sts;
    logic [WIN_N-1:0][PIXEL_BITS-1:0] tap;
    logic [PIXEL_BITS-1:0]            med;
    logic                             acc, take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_IDX_HEIGHT: r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                default:        r_width  <= r_width;
            endcase
        end
    end

    assign cfg.width   = r_width;
    assign cfg.height  = r_height;
    assign cfg.restart = i_cfg_we;

    assign acc         = i_pix.valid && i_pix.ready;
    assign i_pix.ready = front_sts.ready;
    assign take        = tap_sts.valid && (!r_out_valid || o_res.ready);

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_acc     (acc),
        .i_op      (i_pix.operation),
        .i_pix     (i_pix.pixel_value),
        .i_take    (take),
        .o_sts     (front_sts),
        .o_tap_sts (tap_sts),
        .o_tap     (tap)
    );

    mf3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_win (tap),
        .o_med (med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid <= tap_sts.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_med  <= med;
            r_last <= tap_sts.last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.median_value  = r_med;
    assign o_res.last_of_frame = r_last;

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !front_sts.pend_nz)
        else $error("configuration write left results owed");

    a_pre_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_sts.pre_step |=> !front_sts.pre_step)
        else $error("idle window step repeated");

    a_tap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tap_sts.valid && r_out_valid && !o_res.ready) |=> tap_sts.valid)
        else $error("held result lost during output stall");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |-> (!tap_sts.valid || take))
        else $error("transfer accepted with no room for its result");

endmodule

// File: design/mf3_front.sv
// Front end: position counters, flush bookkeeping, two line stores, 3x3 window
// and the registered tap of nine clamped window values. Uses mf3_pkg.
module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cfg                             i_cfg,
    input  logic                             i_acc,
    input  logic                             i_op,
    input  logic [PIXEL_BITS-1:0]            i_pix,
    input  logic                             i_take,
    output t_front_sts                       o_sts,
    output t_tap_sts                         o_tap_sts,
    output logic [WIN_N-1:0][PIXEL_BITS-1:0] o_tap
);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW_A = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (EW_A > WIDTH_BITS) ? EW_A : WIDTH_BITS;
    localparam int PW   = $clog2(MAX_WIDTH + 2);

    logic [CW-1:0]         r_col, n_col;
    logic [ROW_BITS-1:0]   r_row, n_row;
    logic [PW-1:0]         r_pend, n_pend;
    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic [PIXEL_BITS-1:0] r_line_up [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_line_lo [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd_up, r_rd_lo;
    logic                  r_tap_valid, r_tap_last;
    logic [WIN_N-1:0][PIXEL_BITS-1:0] r_tap;

    logic [EW-1:0]         w_ext, eff_w, col_inc;
    logic [ROW_BITS-1:0]   eff_h;
    logic                  w_is_one, h_is_one;
    logic                  pend_nz, due, pre, is_flush;
    logic                  flush_adv, pix_adv, adv, got, wrap, last, tap_adv;
    logic [PW-1:0]         pend_dec;
    logic [PIXEL_BITS-1:0] pix_in;
    logic [PIXEL_BITS-1:0] nc [3];
    logic [PIXEL_BITS-1:0] col_l [3], col_c [3], col_r [3];
    logic                  case_a, lsel_old2, top_clamp, bot_clamp;
    logic [WIN_N-1:0][PIXEL_BITS-1:0] sel;

    always_comb begin
        w_ext = EW'(i_cfg.width);
        if (w_ext == '0) begin
            eff_w = EW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        eff_h    = (i_cfg.height == '0) ? ROW_BITS'(1) : ROW_BITS'(i_cfg.height);
        w_is_one = (eff_w == EW'(1));
        h_is_one = (eff_h == ROW_BITS'(1));
    end

    // Advance control. A flush on a one-row frame first needs a step that
    // yields no result; it is taken on its own cycle.
    always_comb begin
        pend_nz   = (r_pend != '0);
        due       = (r_row >= ROW_BITS'(2)) || (r_row == ROW_BITS'(1) && r_col != '0);
        pre       = pend_nz && !due;
        is_flush  = (i_op == OP_FLUSH);
        flush_adv = i_acc && is_flush && pend_nz;
        pix_adv   = i_acc && !is_flush && !pend_nz;
        adv       = pre || flush_adv || pix_adv;
        got       = (flush_adv || pix_adv) && due;
        pix_in    = pix_adv ? i_pix : '0;
        col_inc   = EW'(r_col) + EW'(1);
        wrap      = (col_inc >= eff_w);
        pend_dec  = r_pend - PW'(1);
        last      = flush_adv && (r_pend == PW'(1));
        tap_adv   = !r_tap_valid || i_take;
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        if (i_cfg.restart) begin
            n_col  = '0;
            n_row  = '0;
            n_pend = '0;
        end else if (adv) begin
            n_col = wrap ? '0 : CW'(col_inc);
            n_row = r_row + ROW_BITS'(wrap);
            if (flush_adv) begin
                n_pend = pend_dec;
                if (pend_dec == '0) begin
                    n_col = '0;
                    n_row = '0;
                end
            end else if (pix_adv && wrap && (r_row + ROW_BITS'(1)) >= eff_h) begin
                n_pend = h_is_one ? PW'(eff_w) : PW'(eff_w) + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_pend      <= '0;
            r_tap_valid <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            if (tap_adv) begin
                r_tap_valid <= got;
            end
        end
    end

    // Line stores: read-modify-write at the current column; the read for the
    // next column is registered, bypassing a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_line_up[r_col] <= r_rd_lo;
            r_line_lo[r_col] <= pix_in;
        end
        if (adv && n_col == r_col) begin
            r_rd_up <= r_rd_lo;
            r_rd_lo <= pix_in;
        end else begin
            r_rd_up <= r_line_up[n_col];
            r_rd_lo <= r_line_lo[n_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
                r_win[r][2] <= nc[r];
            end
        end
    end

    // Column zero finishes the previous row from the old window; other
    // columns use the shifted window. Edge rows and columns are clamped.
    always_comb begin
        nc[0]     = r_rd_up;
        nc[1]     = r_rd_lo;
        nc[2]     = pix_in;
        case_a    = (r_col == '0);
        lsel_old2 = case_a ? w_is_one : (r_col == CW'(1));
        top_clamp = case_a ? (r_row == ROW_BITS'(2)) : (r_row == ROW_BITS'(1));
        bot_clamp = case_a ? (r_row == eff_h + ROW_BITS'(1)) : (r_row == eff_h);
        for (int r = 0; r < 3; r++) begin
            col_l[r] = lsel_old2 ? r_win[r][2] : r_win[r][1];
            col_c[r] = r_win[r][2];
            col_r[r] = case_a ? r_win[r][2] : nc[r];
        end
        sel[0] = top_clamp ? col_l[1] : col_l[0];
        sel[1] = col_l[1];
        sel[2] = bot_clamp ? col_l[1] : col_l[2];
        sel[3] = top_clamp ? col_c[1] : col_c[0];
        sel[4] = col_c[1];
        sel[5] = bot_clamp ? col_c[1] : col_c[2];
        sel[6] = top_clamp ? col_r[1] : col_r[0];
        sel[7] = col_r[1];
        sel[8] = bot_clamp ? col_r[1] : col_r[2];
    end

    always_ff @(posedge i_clk) begin
        if (tap_adv && got) begin
            r_tap      <= sel;
            r_tap_last <= last;
        end
    end

    assign o_sts.ready      = !pre && tap_adv;
    assign o_sts.pend_nz    = pend_nz;
    assign o_sts.pre_step   = pre;
    assign o_tap_sts.valid  = r_tap_valid;
    assign o_tap_sts.last   = r_tap_last;
    assign o_tap            = r_tap;

endmodule

// File: design/mf3_median.sv
// Median of nine pixels by a fixed compare-exchange network.
// Uses mf3_pkg.
module mf3_median
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  logic [WIN_N-1:0][PIXEL_BITS-1:0] i_win,
    output logic [PIXEL_BITS-1:0]            o_med
);
    logic [PIXEL_BITS-1:0] v [WIN_N];
    logic [PIXEL_BITS-1:0] t;

    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            v[i] = i_win[i];
        end
        t = '0;
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
        if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
        if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        if (v[3] > v[4]) begin t = v[3]; v[3] = v[4]; v[4] = t; end
        if (v[6] > v[7]) begin t = v[6]; v[6] = v[7]; v[7] = t; end
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
        if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
        if (v[0] > v[3]) begin t = v[0]; v[0] = v[3]; v[3] = t; end
        if (v[5] > v[8]) begin t = v[5]; v[5] = v[8]; v[8] = t; end
        if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
        if (v[3] > v[6]) begin t = v[3]; v[3] = v[6]; v[6] = t; end
        if (v[1] > v[4]) begin t = v[1]; v[1] = v[4]; v[4] = t; end
        if (v[2] > v[5]) begin t = v[2]; v[2] = v[5]; v[5] = t; end
        if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
        if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
        if (v[6] > v[4]) begin t = v[6]; v[6] = v[4]; v[4] = t; end
        if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
        o_med = v[MID_RANK];
    end

endmodule
